### rtl/core/bse_pkg.sv
// Package for the Bezier spline evaluator core.
// Holds widths, defaults and the segment entry type; depends on nothing.
`default_nettype none
package bse_pkg;
  localparam int TimeW = 48;
  localparam int ValW = 32;
  localparam int CountW = 7;
  localparam int DefMaxSegments = 64;
  localparam int DefFractionBits = 24;
  localparam int InDataW = 280;
  localparam int OutDataW = 32;
  localparam int RegIdxW = 1;
  localparam int CfgDataW = 7;
  localparam logic [RegIdxW-1:0] RegSegmentCount = 1'b0;
  localparam logic [RegIdxW-1:0] RegRepeatEnable = 1'b1;
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEval = 1'b1;

  typedef struct packed {
    logic signed [TimeW-1:0] st;
    logic signed [TimeW-1:0] et;
    logic signed [ValW-1:0] b;
    logic signed [ValW-1:0] c1;
    logic signed [ValW-1:0] c2;
    logic signed [ValW-1:0] v;
  } seg_t;
endpackage
`default_nettype wire

### rtl/core/bezier_spline_evaluator_core.sv
// Top level of the Bezier spline evaluator: segment memory, search,
// divider and interpolation sequencer. Depends on bse_pkg.
//
// Channel  Dir  Contents
// s_axis   in   tdata: slot, eval_time, start_time, stop_time, begin_value,
//               first_control, second_control, end_value; tuser: command
// m_axis   out  tdata: curve_value; tuser: found
// cfg      in   write enable, index, data
//
// Loads may follow back to back. An evaluation holds the input while the
// linear scan of the segment memory and the bit-serial fraction divider run,
// preceded by a bit-serial remainder on the time when repeat is on.
// Reset is synchronous; the memory holds no reset. One word is held in the
// output register, so a stalled result blocks the next evaluation but no load.
`default_nettype none
module bezier_spline_evaluator_core #(
  parameter int MAX_SEGMENTS = bse_pkg::DefMaxSegments,
  parameter int FRACTION_BITS = bse_pkg::DefFractionBits
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // slot[5:0], eval_time, start_time, stop_time, begin_value, first_control,
  // second_control, end_value
  input wire logic [bse_pkg::InDataW-1:0] s_axis_tdata,
  input wire logic s_axis_tuser, // command
  output logic m_axis_tvalid,
  input wire logic m_axis_tready,
  output logic [bse_pkg::OutDataW-1:0] m_axis_tdata, // curve_value
  output logic m_axis_tuser, // found
  input wire logic cfg_we,
  input wire logic [bse_pkg::RegIdxW-1:0] cfg_index,
  input wire logic [bse_pkg::CfgDataW-1:0] cfg_data
);
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int NW = $clog2(MAX_SEGMENTS + 1);
  localparam int TW = bse_pkg::TimeW;
  localparam int VW = bse_pkg::ValW;
  localparam int FB = FRACTION_BITS;
  localparam int FW = FB + 1;
  localparam int CW = $clog2(TW + 1);
  localparam int PW = VW + 1 + FW;

  localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_RDL = 4'd2, S_REM = 4'd3,
    S_SRCH = 4'd4, S_SRCHW = 4'd5, S_FIN = 4'd6, S_FRAC = 4'd7, S_LERP = 4'd8,
    S_LERPW = 4'd9, S_OUT = 4'd10, S_RDS = 4'd11;

  bse_pkg::seg_t mem [MAX_SEGMENTS];
  bse_pkg::seg_t rd;
  logic [AW-1:0] raddr;
  logic [bse_pkg::CountW-1:0] seg_count;
  logic rep_en;
  logic [3:0] state;
  logic [NW-1:0] n;
  logic signed [TW-1:0] t, base;
  logic signed [TW:0] num;
  logic [TW:0] rem, dvs;
  logic [TW-1:0] quo;
  logic neg;
  logic [CW-1:0] cnt;
  logic [NW-1:0] remain;
  logic hit;
  logic [FW-1:0] frac;
  logic signed [VW-1:0] p [4];
  logic [2:0] step;
  logic [1:0] pidx;
  logic signed [VW:0] diff;
  logic signed [PW-1:0] prod;
  logic out_full;
  logic [VW-1:0] out_val;
  logic out_found;

  logic [5:0] in_slot;
  bse_pkg::seg_t in_seg;
  assign in_slot = s_axis_tdata[5:0];
  assign in_seg.st = s_axis_tdata[6 + TW +: TW];
  assign in_seg.et = s_axis_tdata[6 + 2*TW +: TW];
  assign in_seg.b = s_axis_tdata[6 + 3*TW +: VW];
  assign in_seg.c1 = s_axis_tdata[6 + 3*TW + VW +: VW];
  assign in_seg.c2 = s_axis_tdata[6 + 3*TW + 2*VW +: VW];
  assign in_seg.v = s_axis_tdata[6 + 3*TW + 3*VW +: VW];

  assign s_axis_tready = (state == S_IDLE) && !(s_axis_tuser == bse_pkg::CmdEval && out_full);
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata = out_val;
  assign m_axis_tuser = out_found;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tuser == bse_pkg::CmdLoad && 32'(in_slot) < MAX_SEGMENTS) begin
      mem[AW'(in_slot)] <= in_seg;
    end
    rd <= mem[raddr];
  end

  assign num = (TW+1)'(t) - (TW+1)'(base);

  // Interpolation operands for the current de Casteljau step.
  logic signed [VW-1:0] la, lb;
  always_comb begin
    case (step)
      3'd0: begin la = p[0]; lb = p[1]; end
      3'd1: begin la = p[1]; lb = p[2]; end
      3'd2: begin la = p[2]; lb = p[3]; end
      3'd3: begin la = p[0]; lb = p[1]; end
      3'd4: begin la = p[1]; lb = p[2]; end
      default: begin la = p[0]; lb = p[1]; end
    endcase
  end

  assign pidx = (step < 3'd3) ? step[1:0] : ((step < 3'd5) ? 2'(step - 3'd3) : 2'd0);

  logic signed [PW-1:0] lres;
  always_comb begin
    lres = PW'(la) + (prod >>> FB);
  end

  logic [TW:0] rem_sh;
  assign rem_sh = {rem[TW-1:0], quo[TW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= '0;
      rep_en <= 1'b0;
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bse_pkg::RegSegmentCount: seg_count <= cfg_data;
          bse_pkg::RegRepeatEnable: rep_en <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_full && m_axis_tready) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc && s_axis_tuser == bse_pkg::CmdEval) begin
            t <= s_axis_tdata[6 +: TW];
            n <= (32'(seg_count) > MAX_SEGMENTS) ? NW'(MAX_SEGMENTS) : NW'(seg_count);
            raddr <= '0;
            state <= S_RD0;
          end
        end
        S_RD0: begin
          if (n == '0) begin
            out_val <= '0; out_found <= 1'b0; state <= S_OUT;
          end else begin
            raddr <= AW'(n - 1'b1);
            state <= S_RDL;
          end
        end
        S_RDL: begin
          base <= rd.st;
          state <= rep_en ? S_RDS : S_SRCH;
          remain <= n;
          hit <= 1'b0;
        end
        S_RDS: begin
          // rd now holds entry n-1; start the truncating remainder.
          dvs <= (TW+1)'(rd.et) - (TW+1)'(base);
          if (((TW+1)'(rd.et) - (TW+1)'(base)) == '0) begin
            out_val <= '0; out_found <= 1'b0; state <= S_OUT;
          end else begin
            neg <= num[TW];
            quo <= num[TW] ? TW'(-num) : TW'(num);
            rem <= '0;
            cnt <= '0;
            state <= S_REM;
          end
        end
        S_REM: begin
          if (cnt == CW'(TW)) begin
            t <= neg ? TW'((TW+1)'(base) - rem) : TW'((TW+1)'(base) + rem);
            remain <= n;
            state <= S_SRCH;
          end else begin
            if (rem_sh >= (dvs[TW] ? (TW+1)'(-dvs) : dvs) && !dvs[TW]) begin
              rem <= rem_sh - dvs;
            end else if (dvs[TW] && rem_sh >= (TW+1)'(-dvs)) begin
              rem <= rem_sh + dvs;
            end else begin
              rem <= rem_sh;
            end
            quo <= {quo[TW-2:0], 1'b0};
            cnt <= cnt + 1'b1;
          end
        end
        S_SRCH: begin
          // Scan downward from entry n-1: wait for the read at raddr.
          if (remain == '0) begin
            state <= S_FIN;
          end else begin
            state <= S_SRCHW;
          end
        end
        S_SRCHW: begin
          if (rd.st <= t) begin
            hit <= 1'b1;
            state <= S_FIN;
          end else begin
            remain <= remain - 1'b1;
            raddr <= raddr - 1'b1;
            state <= S_SRCH;
          end
        end
        S_FIN: begin
          state <= S_FRAC;
        end
        S_FRAC: begin
          if (!hit || t > rd.et) begin
            out_val <= '0; out_found <= 1'b0; state <= S_OUT;
          end else begin
            p[0] <= rd.b; p[1] <= rd.c1; p[2] <= rd.c2; p[3] <= rd.v;
            if (rd.et == rd.st) begin
              out_val <= VW'(((VW+1)'(rd.b) + (VW+1)'(rd.v)) >>> 1);
              out_found <= 1'b1; state <= S_OUT;
            end else begin
              rem <= (TW+1)'(t) - (TW+1)'(rd.st);
              dvs <= (TW+1)'(rd.et) - (TW+1)'(rd.st);
              frac <= '0; cnt <= '0;
              state <= S_LERP;
              step <= 3'd7;
            end
          end
        end
        S_LERP: begin
          if (step == 3'd7) begin
            if (cnt == '0 && rem >= dvs) begin
              frac <= FW'(1) << FB; step <= 3'd0; cnt <= '0;
            end else if (cnt == CW'(FB)) begin
              step <= 3'd0; cnt <= '0;
            end else begin
              if ({rem[TW-1:0], 1'b0} >= dvs) begin
                rem <= {rem[TW-1:0], 1'b0} - dvs; frac <= {frac[FW-2:0], 1'b1};
              end else begin
                rem <= {rem[TW-1:0], 1'b0}; frac <= {frac[FW-2:0], 1'b0};
              end
              cnt <= cnt + 1'b1;
            end
          end else begin
            diff <= (VW+1)'(lb) - (VW+1)'(la);
            state <= S_LERPW;
          end
        end
        S_LERPW: begin
          if (cnt == '0) begin
            prod <= PW'(diff) * $signed({1'b0, frac});
            cnt <= CW'(1);
          end else begin
            cnt <= '0;
            p[pidx] <= VW'(lres);
            if (step == 3'd5) begin
              out_val <= VW'(lres); out_found <= 1'b1; state <= S_OUT;
            end else begin
              step <= step + 1'b1; state <= S_LERP;
            end
          end
        end
        S_OUT: begin
          if (!out_full || m_axis_tready) begin
            out_full <= 1'b1; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
